// ===== hw/rtl/bad_pkg.sv =====
// ----------------------------------------------------------------------------
// Box average downsampler package
// Shared register codes, field widths and reset defaults.
// ----------------------------------------------------------------------------
package bad_pkg;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  // Parameter defaults
  localparam int DEF_MAX_LINE_WIDTH = 1024;
  localparam int DEF_MAX_SCALE_LOG2 = 3;

  // Register reset values
  localparam logic [10:0] LINE_WIDTH_RST = 11'd256;
  localparam logic [1:0]  SCALE_LOG2_RST = 2'd1;

  // Register index codes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH = 1'b0,
    CFG_SCALE_LOG2 = 1'b1
  } cfg_reg_t;

endpackage

// ===== hw/rtl/box_average_downsampler.sv =====
// ----------------------------------------------------------------------------
// Box average downsampler
// Averages each 2^scale square block of a raster luma stream into one pixel.
// ----------------------------------------------------------------------------
// Pipeline: from input accept through the line store read register and stage 1
//   registers, then the result register that drives out_valid.
// Throughput: one pixel word per cycle; a result word stalled on out_ready
//   holds the input off once the stage behind it also holds a result.
// Reset: synchronous, active low; clears counters, row sum and valid flags.
//   The line store is not cleared; each entry is written before it is read.
module box_average_downsampler #(
  parameter int MAX_LINE_WIDTH = bad_pkg::DEF_MAX_LINE_WIDTH,
  parameter int MAX_SCALE_LOG2 = bad_pkg::DEF_MAX_SCALE_LOG2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bad_pkg::CFG_DATA_W-1:0] cfg_data,
  // pixel input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bad_pkg::PIX_W-1:0]      in_pixel_value,
  input  logic                           in_frame_start,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bad_pkg::PIX_W-1:0]      out_average_value,
  output logic                           out_line_last
);
  import bad_pkg::*;

  localparam int X_W  = $clog2(MAX_LINE_WIDTH);
  localparam int LW_W = $clog2(MAX_LINE_WIDTH + 1);
  localparam int SC_W = $clog2(MAX_SCALE_LOG2 + 1);
  localparam int CX_W = MAX_SCALE_LOG2;
  localparam int RS_W = PIX_W + MAX_SCALE_LOG2;
  localparam int CS_W = PIX_W + 2 * MAX_SCALE_LOG2;

  // configuration registers
  logic [CFG_DATA_W-1:0] line_width_r;
  logic [1:0]            scale_log2_r;

  // position state
  logic [X_W-1:0]  col_pos_r,  col_pos_nxt;
  logic [CX_W-1:0] row_blk_r,  row_blk_nxt;
  logic [RS_W-1:0] row_sum_r,  row_sum_nxt;

  // line store
  logic [CS_W-1:0] col_sums [MAX_LINE_WIDTH];
  logic [CS_W-1:0] col_rd_r;

  // stage 1 registers
  logic            s1_valid_r;
  logic            s1_write_r;
  logic            s1_emit_r;
  logic            s1_first_row_r;
  logic            s1_line_last_r;
  logic [X_W-1:0]  s1_addr_r;
  logic [RS_W-1:0] s1_row_sum_r;
  logic [SC_W-1:0] s1_scale_r;

  // result register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_avg_r;
  logic             out_last_r;

  // stage 0 decode
  logic [LW_W-1:0] lw_eff;
  logic [SC_W-1:0] sc_eff;
  logic [CX_W-1:0] mask;
  logic [X_W-1:0]  x;
  logic [X_W-1:0]  bc;
  logic [LW_W-1:0] blocks;
  logic [CX_W-1:0] cx;
  logic [CX_W-1:0] rib;
  logic            in_blk;
  logic            first_col;
  logic            last_col;
  logic            line_end;
  logic            in_fire;
  logic            s1_adv;
  logic            out_free;
  logic [CS_W-1:0] total;

  // clamp configuration to the supported range
  always_comb begin
    lw_eff = (32'(line_width_r) > 32'(MAX_LINE_WIDTH)) ? LW_W'(MAX_LINE_WIDTH)
                                                      : LW_W'(line_width_r);
    sc_eff = (32'(scale_log2_r) > 32'(MAX_SCALE_LOG2)) ? SC_W'(MAX_SCALE_LOG2)
                                                      : SC_W'(scale_log2_r);
    mask   = CX_W'((32'd1 << sc_eff) - 32'd1);
  end

  // decode the incoming pixel position
  always_comb begin
    x         = in_frame_start ? '0 : col_pos_r;
    rib       = (in_frame_start ? '0 : row_blk_r) & mask;
    bc        = x >> sc_eff;
    blocks    = lw_eff >> sc_eff;
    cx        = CX_W'(x) & mask;
    in_blk    = LW_W'(bc) < blocks;
    first_col = (cx == '0);
    last_col  = (cx == mask);
    line_end  = (LW_W'(x) + LW_W'(1)) >= lw_eff;
  end

  // advance position and row accumulator
  always_comb begin
    row_sum_nxt = in_frame_start ? '0 : row_sum_r;
    if (in_blk) begin
      row_sum_nxt = (first_col ? '0 : row_sum_nxt) + RS_W'(in_pixel_value);
    end
    if (line_end) begin
      col_pos_nxt = '0;
      row_blk_nxt = (rib + CX_W'(1)) & mask;
    end else begin
      col_pos_nxt = x + X_W'(1);
      row_blk_nxt = rib;
    end
  end

  // handshake
  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = !s1_emit_r || out_free;
  assign in_ready  = rst_n && (!s1_valid_r || s1_adv);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = rst_n;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
      scale_log2_r <= SCALE_LOG2_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LINE_WIDTH: line_width_r <= cfg_data;
        CFG_SCALE_LOG2: scale_log2_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_blk_r <= '0;
      row_sum_r <= '0;
    end else if (in_fire) begin
      col_pos_r <= col_pos_nxt;
      row_blk_r <= row_blk_nxt;
      row_sum_r <= row_sum_nxt;
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_write_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
      s1_write_r <= in_blk && last_col && (rib != mask);
      s1_emit_r  <= in_blk && last_col && (rib == mask);
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
      s1_write_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_first_row_r <= (rib == '0);
      s1_line_last_r <= LW_W'(bc) == (blocks - LW_W'(1));
      s1_addr_r      <= bc;
      s1_row_sum_r   <= row_sum_nxt;
      s1_scale_r     <= sc_eff;
    end
  end

  // line store: read at accept, write when a partial column sum retires
  always_ff @(posedge clk) begin
    if (in_fire) begin
      col_rd_r <= col_sums[bc];
    end
    if (s1_valid_r && s1_write_r) begin
      col_sums[s1_addr_r] <= total;
    end
  end

  // combine the column sum with this block row
  assign total = (s1_first_row_r ? '0 : col_rd_r) + CS_W'(s1_row_sum_r);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_emit_r && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_emit_r && out_free) begin
      out_avg_r  <= PIX_W'(total >> {s1_scale_r, 1'b0});
      out_last_r <= s1_line_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_average_value = out_avg_r;
  assign out_line_last     = out_last_r;

endmodule

// ===== hw/rtl/bad_chk.sv =====
// ----------------------------------------------------------------------------
// Box average downsampler port checker
// Watches the top level handshakes for ordering and stall behavior.
// ----------------------------------------------------------------------------
module bad_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_average_value,
  input logic       out_line_last
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average_value) &&
      $stable(out_line_last))
    else $error("result word changed while stalled");

  // drop results on reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a result after an empty result register needs an input word accepted through stage 1
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result word without an input word");

  // input is never blocked when the result register is empty
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind box_average_downsampler bad_chk u_bad_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_average_value (out_average_value),
  .out_line_last     (out_line_last)
);
